@@ rtl/core/sgps_pkg.sv @@
// Shared types, register codes and glyph tables for the scrolling glyph plane sequencer.
package sgps_pkg;

	localparam int MsgLen = 32;
	localparam int CubeSize = 8;
	localparam int MaskW = 35;

	// configuration register indexes
	localparam logic [2:0] RegMsgA = 3'd0;
	localparam logic [2:0] RegMsgB = 3'd1;
	localparam logic [2:0] RegMsgC = 3'd2;
	localparam logic [2:0] RegMsgD = 3'd3;
	localparam logic [2:0] RegBaseColor = 3'd4;
	localparam logic [2:0] RegGapLength = 3'd5;
	localparam logic [2:0] RegStepDivider = 3'd6;

	localparam logic [23:0] WhiteColor = 24'hFFFFFF;
	localparam logic [7:0] GapLengthReset = 8'd8;
	localparam logic [3:0] StepDividerReset = 4'd2;
	localparam logic [7:0] SpaceChar = 8'h20;
	localparam logic [5:0] BlankSlot = 6'd36;

	typedef struct packed {
		logic [3:0][63:0] message;
		logic [23:0] base_color;
		logic [7:0] gap_length;
		logic [3:0] step_divider;
	} cfg_t;

	typedef struct packed {
		logic [5:0] char_index;
		logic [2:0] plane_position;
		logic [7:0] gap_count;
		logic [3:0] frame_divider;
		logic [23:0] current_color;
	} state_t;

	typedef struct packed {
		logic restart;
		logic [23:0] random_bits;
	} frame_t;

	typedef struct packed {
		logic main_lit;
		logic [2:0] main_plane;
		logic shade_lit;
		logic [2:0] shade_plane;
		logic [MaskW-1:0] voxel_mask;
		logic [7:0] color_red;
		logic [7:0] color_green;
		logic [7:0] color_blue;
	} result_t;

	// ASCII code to glyph slot: A-Z, then 0-9, then blank
	function automatic logic [5:0] glyph_slot(input logic [7:0] c);
		logic [7:0] u;
		logic [7:0] d;
		u = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
		d = u - 8'h30;
		if (u >= 8'h41 && u <= 8'h5A) begin
			glyph_slot = 6'(u - 8'h41);
		end else if (u >= 8'h30 && u <= 8'h39) begin
			glyph_slot = 6'd26 + d[5:0];
		end else begin
			glyph_slot = BlankSlot;
		end
	endfunction

	// Glyph rows top first; top row lands at height 6, so rows concatenate MSB first.
	function automatic logic [MaskW-1:0] glyph_mask(input logic [5:0] slot);
		case (slot)
			6'd0: glyph_mask = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
			6'd1: glyph_mask = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
			6'd2: glyph_mask = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
			6'd3: glyph_mask = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
			6'd4: glyph_mask = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
			6'd5: glyph_mask = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
			6'd6: glyph_mask = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
			6'd7: glyph_mask = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
			6'd8: glyph_mask = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
			6'd9: glyph_mask = {5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E};
			6'd10: glyph_mask = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
			6'd11: glyph_mask = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
			6'd12: glyph_mask = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
			6'd13: glyph_mask = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
			6'd14: glyph_mask = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
			6'd15: glyph_mask = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
			6'd16: glyph_mask = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
			6'd17: glyph_mask = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
			6'd18: glyph_mask = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
			6'd19: glyph_mask = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
			6'd20: glyph_mask = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
			6'd21: glyph_mask = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
			6'd22: glyph_mask = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
			6'd23: glyph_mask = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
			6'd24: glyph_mask = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
			6'd25: glyph_mask = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
			6'd26: glyph_mask = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
			6'd27: glyph_mask = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
			6'd28: glyph_mask = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
			6'd29: glyph_mask = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
			6'd30: glyph_mask = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h01, 5'h01, 5'h01};
			6'd31: glyph_mask = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
			6'd32: glyph_mask = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
			6'd33: glyph_mask = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
			6'd34: glyph_mask = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
			6'd35: glyph_mask = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
			default: glyph_mask = '0;
		endcase
	endfunction

	// random channel level: 200 + (byte mod 56), remainder by parallel compares
	function automatic logic [7:0] rand_level(input logic [7:0] b);
		logic [7:0] r;
		if (b >= 8'd224) begin
			r = b - 8'd224;
		end else if (b >= 8'd168) begin
			r = b - 8'd168;
		end else if (b >= 8'd112) begin
			r = b - 8'd112;
		end else if (b >= 8'd56) begin
			r = b - 8'd56;
		end else begin
			r = b;
		end
		rand_level = 8'd200 + r;
	endfunction

	// 5-bit by 4-bit remainder, restoring, one bit per step
	function automatic logic [3:0] small_mod(input logic [4:0] a, input logic [3:0] d);
		logic [4:0] rem;
		rem = '0;
		for (int i = 4; i >= 0; i--) begin
			rem = {rem[3:0], a[i]};
			if (rem >= {1'b0, d}) begin
				rem = rem - {1'b0, d};
			end
		end
		small_mod = rem[3:0];
	endfunction

endpackage

@@ rtl/core/sgps_chan_if.sv @@
// Valid/ready channel interfaces for frame ticks and plane results.
interface sgps_frame_if;
	logic valid;
	logic ready;
	logic restart;
	logic [23:0] random_bits;

	modport source(output valid, restart, random_bits, input ready);
	modport sink(input valid, restart, random_bits, output ready);
endinterface

interface sgps_result_if;
	logic valid;
	logic ready;
	logic main_lit;
	logic [2:0] main_plane;
	logic shade_lit;
	logic [2:0] shade_plane;
	logic [sgps_pkg::MaskW-1:0] voxel_mask;
	logic [7:0] color_red;
	logic [7:0] color_green;
	logic [7:0] color_blue;

	modport source(output valid, main_lit, main_plane, shade_lit, shade_plane, voxel_mask,
		color_red, color_green, color_blue, input ready);
	modport sink(input valid, main_lit, main_plane, shade_lit, shade_plane, voxel_mask,
		color_red, color_green, color_blue, output ready);
endinterface

@@ rtl/core/sgps_cfg_regs.sv @@
// Configuration register bank written through the plain write port.
module sgps_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [2:0] wr_index,
	input  logic [63:0] wr_data,
	output sgps_pkg::cfg_t cfg
);

	sgps_pkg::cfg_t cfg_q;

	// register writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.message <= '0;
			cfg_q.base_color <= '0;
			cfg_q.gap_length <= sgps_pkg::GapLengthReset;
			cfg_q.step_divider <= sgps_pkg::StepDividerReset;
		end else if (wr_en) begin
			case (wr_index)
				sgps_pkg::RegMsgA: cfg_q.message[0] <= wr_data;
				sgps_pkg::RegMsgB: cfg_q.message[1] <= wr_data;
				sgps_pkg::RegMsgC: cfg_q.message[2] <= wr_data;
				sgps_pkg::RegMsgD: cfg_q.message[3] <= wr_data;
				sgps_pkg::RegBaseColor: cfg_q.base_color <= wr_data[23:0];
				sgps_pkg::RegGapLength: cfg_q.gap_length <= wr_data[7:0];
				sgps_pkg::RegStepDivider: cfg_q.step_divider <= wr_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/sgps_step.sv @@
// Per-frame next-state and result logic: gap timing, glyph fetch and plane movement.
module sgps_step (
	input  sgps_pkg::cfg_t cfg,
	input  sgps_pkg::state_t cur,
	input  sgps_pkg::frame_t frame,
	output sgps_pkg::state_t nxt,
	output sgps_pkg::result_t res
);

	sgps_pkg::state_t st;
	logic [31:0] zero_chr;
	logic [31:0][7:0] chars;
	logic [5:0] idx_inc;
	logic end_cur;
	logic end_inc;
	logic [7:0] chr;
	logic [7:0] gap_val;
	logic [3:0] div;
	logic [3:0] fd_new;
	logic [7:0] gap_dec;
	logic [2:0] main_pl;

	// message bytes and terminator flags
	always_comb begin
		chars = cfg.message;
		for (int k = 0; k < sgps_pkg::MsgLen; k++) begin
			zero_chr[k] = (chars[k] == 8'd0);
		end
	end

	// restart is applied before the frame is handled
	always_comb begin
		st = cur;
		if (frame.restart) begin
			st.char_index = '0;
			st.plane_position = '0;
			st.gap_count = '0;
			st.frame_divider = '0;
			st.current_color = (cfg.base_color != '0) ? cfg.base_color : sgps_pkg::WhiteColor;
		end
	end

	assign idx_inc = st.char_index + 6'd1;

	// end of message: index past the buffer, or a terminator at or before it
	always_comb begin
		end_cur = st.char_index[5];
		end_inc = idx_inc[5];
		for (int k = 0; k < sgps_pkg::MsgLen; k++) begin
			if (zero_chr[k] && (5'(k) <= st.char_index[4:0])) begin
				end_cur = 1'b1;
			end
			if (zero_chr[k] && (5'(k) <= idx_inc[4:0])) begin
				end_inc = 1'b1;
			end
		end
	end

	assign chr = chars[st.char_index[4:0]];
	assign gap_val = (cfg.gap_length == '0) ? 8'd1 : cfg.gap_length;
	assign div = (cfg.step_divider == '0) ? 4'd1 : cfg.step_divider;
	assign fd_new = sgps_pkg::small_mod({1'b0, st.frame_divider} + 5'd1, div);
	assign gap_dec = st.gap_count - 8'd1;
	assign main_pl = ~st.plane_position;

	// frame sequencing
	always_comb begin
		nxt = st;
		res = '0;
		if (st.gap_count != '0) begin
			nxt.gap_count = gap_dec;
			if (gap_dec == '0) begin
				nxt.char_index = idx_inc;
				if (end_inc) begin
					nxt.char_index = '0;
					nxt.plane_position = '0;
					if (cfg.base_color == '0) begin
						nxt.current_color = {sgps_pkg::rand_level(frame.random_bits[23:16]),
							sgps_pkg::rand_level(frame.random_bits[15:8]),
							sgps_pkg::rand_level(frame.random_bits[7:0])};
					end
				end
			end
		end else if (end_cur || chr == sgps_pkg::SpaceChar) begin
			nxt.gap_count = gap_val;
		end else begin
			res.main_lit = 1'b1;
			res.main_plane = main_pl;
			res.shade_lit = (st.plane_position != '0);
			res.shade_plane = (st.plane_position != '0) ? main_pl + 3'd1 : 3'd0;
			res.voxel_mask = sgps_pkg::glyph_mask(sgps_pkg::glyph_slot(chr));
			res.color_red = st.current_color[23:16];
			res.color_green = st.current_color[15:8];
			res.color_blue = st.current_color[7:0];
			nxt.frame_divider = fd_new;
			if (fd_new == '0) begin
				nxt.plane_position = st.plane_position + 3'd1;
				if (st.plane_position == 3'(sgps_pkg::CubeSize - 1)) begin
					nxt.char_index = idx_inc;
					if (end_inc) begin
						nxt.gap_count = gap_val;
					end
				end
			end
		end
	end

endmodule

@@ rtl/core/scrolling_glyph_plane_sequencer_top.sv @@
// Top level: frame input register, sequencer state, result register and handshakes.
//
// Usage:
//   frame  : one transaction per frame tick (restart, random_bits).
//   result : one transaction per frame tick with plane indexes, the 35-bit voxel
//            mask and the main-plane color; blank frames come out all zero.
//   wr_en/wr_index/wr_data : register writes, taken on any edge with wr_en high;
//            write only while no frame is in flight.
// Path: an accepted frame is held in the input register, then the step logic
//   writes its result into the result register, which drives result.
// Throughput: one frame per cycle while result is not held off; the state update is a
//   single combinational pass of glyph ROM lookup, end-of-message check and counter updates.
// Reset: arst_n clears the position, gap and divider counters, sets the color
//   to white and the registers to their defaults; no clearing pass is needed.
// Stall: when result is held off, the finished transaction waits in the result
//   register and one more frame is held in the input register; frame.ready then
//   drops until the result is taken.
module scrolling_glyph_plane_sequencer_top (
	input  logic clk,
	input  logic arst_n,
	sgps_frame_if.sink frame,
	sgps_result_if.source result,
	input  logic wr_en,
	input  logic [2:0] wr_index,
	input  logic [63:0] wr_data
);

	sgps_pkg::cfg_t cfg;
	sgps_pkg::state_t state_q;
	sgps_pkg::state_t state_nxt;
	sgps_pkg::frame_t frame_s1;
	sgps_pkg::result_t res_nxt;
	sgps_pkg::result_t res_q;
	logic valid_s1;
	logic out_valid_q;
	logic advance;

	sgps_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.cfg(cfg)
	);

	sgps_step u_step (
		.cfg(cfg),
		.cur(state_q),
		.frame(frame_s1),
		.nxt(state_nxt),
		.res(res_nxt)
	);

	// the staged frame moves on when the result register is free or being drained
	assign advance = valid_s1 && (!out_valid_q || result.ready);
	assign frame.ready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.valid && frame.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			frame_s1.restart <= frame.restart;
			frame_s1.random_bits <= frame.random_bits;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.char_index <= '0;
			state_q.plane_position <= '0;
			state_q.gap_count <= '0;
			state_q.frame_divider <= '0;
			state_q.current_color <= sgps_pkg::WhiteColor;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid = out_valid_q;
	assign result.main_lit = res_q.main_lit;
	assign result.main_plane = res_q.main_plane;
	assign result.shade_lit = res_q.shade_lit;
	assign result.shade_plane = res_q.shade_plane;
	assign result.voxel_mask = res_q.voxel_mask;
	assign result.color_red = res_q.color_red;
	assign result.color_green = res_q.color_green;
	assign result.color_blue = res_q.color_blue;

endmodule
